FILE: sv/armp_pkg.sv
// Package for affine_recurrence_mod_power: widths, commands and status types.
// No dependencies.
package armp_pkg;
	localparam int VW = 62;
	localparam int KW = 63;
	localparam int CW = $clog2(VW + 1);

	typedef logic [VW-1:0] val_t;
	typedef logic [KW-1:0] idx_t;

	// datapath operations
	localparam logic [2:0] OP_LOAD  = 3'd0;
	localparam logic [2:0] OP_RED_G = 3'd1;
	localparam logic [2:0] OP_RED_H = 3'd2;
	localparam logic [2:0] OP_MUL   = 3'd3;
	localparam logic [2:0] OP_ADD   = 3'd4;
	localparam logic [2:0] OP_NONE  = 3'd5;

	// register file selectors
	localparam logic [2:0] R_RP = 3'd0;
	localparam logic [2:0] R_RQ = 3'd1;
	localparam logic [2:0] R_BP = 3'd2;
	localparam logic [2:0] R_BQ = 3'd3;
	localparam logic [2:0] R_H  = 3'd4;
	localparam logic [2:0] R_T  = 3'd5;
	localparam logic [2:0] R_U  = 3'd6;

	typedef struct packed {
		logic       go;
		logic [2:0] op;
		logic [2:0] sa;
		logic [2:0] sb;
		logic [2:0] dst;
		logic       shift_e;
	} cmd_t;

	typedef struct packed {
		logic done;
		logic e_zero;
		logic e_lsb;
		logic trivial;
	} sts_t;
endpackage

FILE: sv/armp_datapath.sv
// Datapath: operand registers, exponent register and a shared bit-serial
// modular multiply / reduce unit. Depends on armp_pkg.
module armp_datapath (
	input  logic            clk,
	input  logic            arst_n,
	input  armp_pkg::cmd_t  cmd,
	input  armp_pkg::val_t  g_in,
	input  armp_pkg::val_t  h_in,
	input  armp_pkg::val_t  m_in,
	input  armp_pkg::idx_t  k_in,
	output armp_pkg::sts_t  sts,
	output armp_pkg::val_t  result
);
	import armp_pkg::*;

	val_t rf_q [7];
	val_t m_q;
	idx_t e_q;
	logic triv_q;
	logic busy_q;
	logic [2:0] op_q, dst_q;
	logic [CW-1:0] cnt_q;
	val_t x_q, y_q;
	logic [VW:0] acc_q;
	logic done_q;

	logic [VW:0] dbl, dbl_r, add1, add1_r;
	logic [VW:0] m_ext;

	assign m_ext = {1'b0, m_q};

	always_comb begin
		// mul step: acc = 2acc (+x); reduce step: acc = 2acc + bit, then subtract
		dbl = {acc_q[VW-1:0], (op_q == OP_MUL) ? 1'b0 : y_q[VW-1]};
		dbl_r = (dbl >= m_ext) ? dbl - m_ext : dbl;
		add1 = dbl_r + {1'b0, x_q};
		add1_r = (add1 >= m_ext) ? add1 - m_ext : add1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
			op_q <= OP_NONE;
			dst_q <= R_T;
		end else begin
			done_q <= 1'b0;
			if (cmd.go) begin
				op_q <= cmd.op;
				dst_q <= cmd.dst;
				case (cmd.op)
					OP_LOAD: begin
						done_q <= 1'b1;
					end
					OP_ADD: begin
						done_q <= 1'b1;
					end
					OP_RED_G, OP_RED_H, OP_MUL: begin
						busy_q <= 1'b1;
						cnt_q <= CW'(VW);
					end
					default: begin
						done_q <= 1'b1;
					end
				endcase
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.go) begin
			case (cmd.op)
				OP_LOAD: begin
					m_q <= m_in;
					e_q <= k_in - 1'b1;
					triv_q <= (m_in == '0) || (k_in == '0);
					rf_q[R_H] <= h_in;
					rf_q[R_T] <= g_in;
				end
				OP_ADD: begin
					add_res: begin
						logic [VW:0] s;
						s = {1'b0, rf_q[cmd.sa]} + {1'b0, rf_q[cmd.sb]};
						rf_q[cmd.dst] <= (s >= m_ext) ? VW'(s - m_ext) : s[VW-1:0];
					end
				end
				OP_RED_G, OP_RED_H, OP_MUL: begin
					acc_q <= '0;
					x_q <= (cmd.op == OP_MUL) ? rf_q[cmd.sa] : '0;
					y_q <= rf_q[cmd.sb];
				end
				default: begin
					if (cmd.shift_e) e_q <= e_q >> 1;
					if (cmd.sa == R_RP) begin
						rf_q[R_RP] <= (m_q == VW'(1)) ? '0 : VW'(1);
						rf_q[R_RQ] <= '0;
						rf_q[R_BQ] <= rf_q[R_H];
					end
				end
			endcase
		end else if (busy_q) begin
			y_q <= y_q << 1;
			if (op_q == OP_MUL) begin
				acc_q <= y_q[VW-1] ? add1_r : dbl_r;
			end else begin
				acc_q <= dbl_r;
			end
			if (cnt_q == CW'(1)) begin
				rf_q[dst_q] <= (op_q == OP_MUL) ?
					(y_q[VW-1] ? add1_r[VW-1:0] : dbl_r[VW-1:0]) : dbl_r[VW-1:0];
			end
		end
	end

	assign sts.done = done_q;
	assign sts.e_zero = (e_q == '0);
	assign sts.e_lsb = e_q[0];
	assign sts.trivial = triv_q;
	assign result = rf_q[R_U];
endmodule

FILE: sv/armp_ctrl.sv
// Controller: sequences square-and-multiply over the datapath.
// Depends on armp_pkg.
module armp_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  armp_pkg::sts_t sts,
	output armp_pkg::cmd_t cmd,
	output logic           busy,
	output logic           strobe,
	output logic           zero_out
);
	import armp_pkg::*;

	localparam logic [4:0] S_IDLE = 5'd0, S_LD = 5'd1, S_RG = 5'd2, S_RH = 5'd3,
		S_INIT = 5'd4, S_TEST = 5'd5, S_M1 = 5'd6, S_M2 = 5'd7, S_M3 = 5'd8,
		S_Q1 = 5'd9, S_Q2 = 5'd10, S_Q3 = 5'd11,
		S_SH = 5'd12, S_F1 = 5'd13, S_F2 = 5'd14, S_OUT = 5'd15;

	logic [4:0] st_q, nx;
	logic issued_q;
	cmd_t c;

	// each state but IDLE, TEST and OUT issues one command once, then waits for done
	always_comb begin
		c = '{go: 1'b0, op: OP_NONE, sa: R_T, sb: R_T, dst: R_T, shift_e: 1'b0};
		nx = st_q;
		case (st_q)
			S_IDLE: if (start) begin
				nx = S_LD;
			end
			S_LD:   begin c.op = OP_LOAD; end
			S_RG:   begin c.op = OP_RED_G; c.sb = R_T;  c.dst = R_BP; end
			S_RH:   begin c.op = OP_RED_H; c.sb = R_H;  c.dst = R_H; end
			S_INIT: begin c.op = OP_NONE; c.sa = R_RP; end
			S_M1:   begin c.op = OP_MUL; c.sa = R_RP; c.sb = R_BQ; c.dst = R_U; end
			S_M2:   begin c.op = OP_ADD; c.sa = R_U; c.sb = R_RQ; c.dst = R_RQ; end
			S_M3:   begin c.op = OP_MUL; c.sa = R_RP; c.sb = R_BP; c.dst = R_RP; end
			S_Q1:   begin c.op = OP_MUL; c.sa = R_BP; c.sb = R_BQ; c.dst = R_U; end
			S_Q2:   begin c.op = OP_ADD; c.sa = R_U; c.sb = R_BQ; c.dst = R_BQ; end
			S_Q3:   begin c.op = OP_MUL; c.sa = R_BP; c.sb = R_BP; c.dst = R_BP; end
			S_SH:   begin c.op = OP_NONE; c.shift_e = 1'b1; end
			S_F1:   begin c.op = OP_MUL; c.sa = R_RP; c.sb = R_H; c.dst = R_U; end
			S_F2:   begin c.op = OP_ADD; c.sa = R_U; c.sb = R_RQ; c.dst = R_U; end
			default: begin end
		endcase
		if (st_q != S_IDLE && st_q != S_TEST && st_q != S_OUT && !issued_q) c.go = 1'b1;
		if (issued_q && sts.done) begin
			case (st_q)
				S_LD:   nx = sts.trivial ? S_OUT : S_RG;
				S_RG:   nx = S_RH;
				S_RH:   nx = S_INIT;
				S_INIT: nx = S_TEST;
				S_M1:   nx = S_M2;
				S_M2:   nx = S_M3;
				S_M3:   nx = S_Q1;
				S_Q1:   nx = S_Q2;
				S_Q2:   nx = S_Q3;
				S_Q3:   nx = S_SH;
				S_SH:   nx = S_TEST;
				S_F1:   nx = S_F2;
				S_F2:   nx = S_OUT;
				default: nx = S_IDLE;
			endcase
		end
		if (st_q == S_TEST) nx = sts.e_zero ? S_F1 : (sts.e_lsb ? S_M1 : S_Q1);
		if (st_q == S_OUT) nx = S_IDLE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			issued_q <= 1'b0;
		end else begin
			st_q <= nx;
			if (nx != st_q) issued_q <= 1'b0;
			else if (c.go) issued_q <= 1'b1;
		end
	end

	assign cmd = c;
	assign busy = (st_q != S_IDLE);
	assign strobe = (st_q == S_OUT);
	assign zero_out = sts.trivial;
endmodule

FILE: sv/affine_recurrence_mod_power.sv
// Top level of affine_recurrence_mod_power: controller plus datapath.
// Depends on armp_pkg, armp_ctrl, armp_datapath.
//  channel | ports                                         | handshake
//  in      | multiplier addend modulus term_index           | start & !busy
//  out     | term_value                                     | done (one cycle)
// Modular products run one at a time on the single shared shift-add unit,
// up to 4 products per exponent bit.
// arst_n clears the controller; the receiver cannot stall the result.
module affine_recurrence_mod_power (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  armp_pkg::val_t       multiplier,
	input  armp_pkg::val_t       addend,
	input  armp_pkg::val_t       modulus,
	input  armp_pkg::idx_t       term_index,
	output logic                 done,
	output armp_pkg::val_t       term_value
);
	import armp_pkg::*;

	cmd_t cmd;
	sts_t sts;
	val_t res;
	logic zero_out;
	val_t g_q, h_q, m_q;
	idx_t k_q;

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			g_q <= multiplier;
			h_q <= addend;
			m_q <= modulus;
			k_q <= term_index;
		end
	end

	armp_ctrl u_ctrl (
		.clk, .arst_n, .start, .sts, .cmd, .busy, .strobe(done), .zero_out
	);

	armp_datapath u_dp (
		.clk, .arst_n, .cmd, .g_in(g_q), .h_in(h_q), .m_in(m_q), .k_in(k_q),
		.sts, .result(res)
	);

	assign term_value = zero_out ? '0 : res;
endmodule

FILE: sv/armp_checker.sv
// Port-level checker for affine_recurrence_mod_power, with its bind.
// Depends on armp_pkg.
module armp_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input logic           busy,
	input logic           done,
	input armp_pkg::val_t term_value
);
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("done while idle");
	a_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done longer than one cycle");
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("start not taken");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy) else $error("busy after done");
	a_value_known: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !$isunknown(term_value)) else $error("unknown term_value");
endmodule

bind affine_recurrence_mod_power armp_checker u_chk (
	.clk, .arst_n, .start, .busy, .done, .term_value
);
